/* sv/pff_pkg.sv */
// Shared constants, types and the digit character function of the printf field formatter.
`default_nettype none

package pff_pkg;

    localparam logic [5:0] MAX_FIELD  = 6'd62;
    localparam int         DEC_DIGITS = 10;
    localparam int         DIG_W      = 4 * DEC_DIGITS;

    localparam logic [2:0] OP_LIT  = 3'd0;
    localparam logic [2:0] OP_PCT  = 3'd1;
    localparam logic [2:0] OP_CHR  = 3'd2;
    localparam logic [2:0] OP_SDEC = 3'd3;
    localparam logic [2:0] OP_UDEC = 3'd4;
    localparam logic [2:0] OP_HEXL = 3'd5;
    localparam logic [2:0] OP_HEXU = 3'd6;

    localparam logic [1:0] SK_SHORT = 2'd1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;

    typedef struct packed {
        logic             done;
        logic [3:0]       tlen;
        logic [DIG_W-1:0] digits;
    } pff_conv_t;

    typedef struct packed {
        logic [5:0] lead;
        logic [5:0] trail;
        logic [1:0] plen;
        logic [7:0] pfx0;
        logic [7:0] pfx1;
        logic [5:0] zeros;
        logic [3:0] tlen;
        logic [5:0] total;
        logic       is_num;
        logic       upper;
        logic [7:0] txt;
    } pff_plan_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        begin
            if (d < 4'd10)
                c = CH_ZERO + {4'd0, d};
            else if (upper)
                c = 8'h41 + {4'd0, d} - 8'd10;
            else
                c = 8'h61 + {4'd0, d} - 8'd10;
            return c;
        end
    endfunction

endpackage

`default_nettype wire

/* sv/pff_conv.sv */
// Bit-serial binary to BCD converter (hex values load directly) with nibble-serial leading zero strip.
`default_nettype none

module pff_conv
    import pff_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        load,
    input  wire logic [31:0] mag,
    input  wire logic        is_hex,
    input  wire logic        is_short,
    output pff_conv_t        res
);

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_DABBLE,
        CV_ALIGN
    } cv_state_t;

    cv_state_t        state_reg;
    logic [DIG_W-1:0] digits_reg;
    logic [31:0]      bin_reg;
    logic [5:0]       bits_reg;
    logic [3:0]       tlen_reg;
    logic             done_reg;
    logic [DIG_W-1:0] adj_next;

    // add three to every BCD digit of five or more before the shift
    always_comb
    begin
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (digits_reg[4*i +: 4] >= 4'd5)
                adj_next[4*i +: 4] = digits_reg[4*i +: 4] + 4'd3;
            else
                adj_next[4*i +: 4] = digits_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
            bits_reg  <= 6'd0;
            tlen_reg  <= 4'(DEC_DIGITS);
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                CV_IDLE:
                begin
                    if (load)
                    begin
                        tlen_reg <= 4'(DEC_DIGITS);
                        if (is_hex)
                        begin
                            digits_reg <= {{(DIG_W-32){1'b0}}, mag};
                            state_reg  <= CV_ALIGN;
                        end
                        else
                        begin
                            digits_reg <= '0;
                            bin_reg    <= is_short ? {mag[15:0], 16'h0} : mag;
                            bits_reg   <= is_short ? 6'd16 : 6'd32;
                            state_reg  <= CV_DABBLE;
                        end
                    end
                end
                CV_DABBLE:
                begin
                    digits_reg <= {adj_next[DIG_W-2:0], bin_reg[31]};
                    bin_reg    <= {bin_reg[30:0], 1'b0};
                    bits_reg   <= bits_reg - 6'd1;
                    if (bits_reg == 6'd1)
                        state_reg <= CV_ALIGN;
                end
                CV_ALIGN:
                begin
                    // drop one leading zero digit per cycle, keep at least one
                    if (digits_reg[DIG_W-1 -: 4] == 4'd0 && tlen_reg > 4'd1)
                    begin
                        digits_reg <= {digits_reg[DIG_W-5:0], 4'd0};
                        tlen_reg   <= tlen_reg - 4'd1;
                    end
                    else
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= CV_IDLE;
                    end
                end
                default:
                    state_reg <= CV_IDLE;
            endcase
        end
    end

    assign res.done   = done_reg;
    assign res.tlen   = tlen_reg;
    assign res.digits = digits_reg;

endmodule

`default_nettype wire

/* sv/pff_emit.sv */
// Character sequencer: spaces, prefix, zero fill, digits or text, spaces, one per cycle.
`default_nettype none

module pff_emit
    import pff_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire pff_plan_t        plan,
    input  wire logic [DIG_W-1:0] digits,
    output logic                  busy,
    output logic                  strobe,
    output logic [7:0]            out_char,
    output logic                  last
);

    logic [5:0]       lead_reg;
    logic [5:0]       trail_reg;
    logic [1:0]       plen_reg;
    logic [7:0]       pfx0_reg;
    logic [7:0]       pfx1_reg;
    logic [5:0]       zeros_reg;
    logic [3:0]       tlen_reg;
    logic [5:0]       remain_reg;
    logic             is_num_reg;
    logic             upper_reg;
    logic [7:0]       txt_reg;
    logic [DIG_W-1:0] digits_reg;
    logic             strobe_reg;
    logic [7:0]       char_reg;
    logic             last_reg;
    logic [7:0]       text_char;

    assign text_char = is_num_reg ? digit_char(digits_reg[DIG_W-1 -: 4], upper_reg) : txt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg   <= 6'd0;
            trail_reg  <= 6'd0;
            plen_reg   <= 2'd0;
            zeros_reg  <= 6'd0;
            tlen_reg   <= 4'd0;
            remain_reg <= 6'd0;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (load)
        begin
            lead_reg   <= plan.lead;
            trail_reg  <= plan.trail;
            plen_reg   <= plan.plen;
            pfx0_reg   <= plan.pfx0;
            pfx1_reg   <= plan.pfx1;
            zeros_reg  <= plan.zeros;
            tlen_reg   <= plan.tlen;
            remain_reg <= plan.total;
            is_num_reg <= plan.is_num;
            upper_reg  <= plan.upper;
            txt_reg    <= plan.txt;
            digits_reg <= digits;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else if (remain_reg != 6'd0)
        begin
            strobe_reg <= 1'b1;
            last_reg   <= (remain_reg == 6'd1);
            remain_reg <= remain_reg - 6'd1;
            priority if (lead_reg != 6'd0)
            begin
                char_reg <= CH_SPACE;
                lead_reg <= lead_reg - 6'd1;
            end
            else if (plen_reg != 2'd0)
            begin
                char_reg <= pfx0_reg;
                pfx0_reg <= pfx1_reg;
                plen_reg <= plen_reg - 2'd1;
            end
            else if (zeros_reg != 6'd0)
            begin
                char_reg  <= CH_ZERO;
                zeros_reg <= zeros_reg - 6'd1;
            end
            else if (tlen_reg != 4'd0)
            begin
                char_reg   <= text_char;
                digits_reg <= {digits_reg[DIG_W-5:0], 4'd0};
                tlen_reg   <= tlen_reg - 4'd1;
            end
            else
            begin
                char_reg  <= CH_SPACE;
                trail_reg <= trail_reg - 6'd1;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
    end

    assign busy     = (remain_reg != 6'd0);
    assign strobe   = strobe_reg;
    assign out_char = char_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

/* sv/printf_field_formatter_core.sv */
// Top level of the printf field formatter: item decode, field planning, sequencing.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------------
//  item in  | start, busy        | op, size_kind, value, flag_*, field_width,
//           |                    | has_precision, digit_precision
//  char out | strobe (no stall)  | out_char, last
//
// After the accept, literal, percent and char items pass the plan state and then send
// the field's N characters. Hex and decimal items first pass the converter, where
// decimal values take 32 (16 for short) shifts of the bit-serial BCD converter and both
// strip leading zero nibbles (2..9 hex, 0..9 decimal). busy falls at the edge that takes
// the last character; an item with nothing to send goes from plan back to idle.
// Reset clears all control state; the receiver cannot stall, each character shows once.
`default_nettype none

module printf_field_formatter_core
    import pff_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  op,
    input  wire logic [1:0]  size_kind,
    input  wire logic [31:0] value,
    input  wire logic        flag_left,
    input  wire logic        flag_plus,
    input  wire logic        flag_space,
    input  wire logic        flag_alt,
    input  wire logic        flag_zero,
    input  wire logic [5:0]  field_width,
    input  wire logic        has_precision,
    input  wire logic [5:0]  digit_precision,
    output logic             strobe,
    output logic [7:0]       out_char,
    output logic             last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_PLAN,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [2:0]  op_reg;
    logic [7:0]  chr_reg;
    logic        neg_reg;
    logic        left_reg;
    logic        plus_reg;
    logic        space_reg;
    logic        alt_reg;
    logic        zero_reg;
    logic [5:0]  w_reg;
    logic        hp_reg;
    logic [5:0]  pr_reg;

    logic        accept;
    logic        is_short;
    logic        is_hex_in;
    logic        is_num_in;
    logic        neg_in;
    logic [31:0] x_in;
    logic [31:0] negx_in;
    logic [31:0] mag_in;

    pff_conv_t   conv_res;
    pff_plan_t   plan;
    logic        emit_load;
    logic        emit_busy;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // operand decode at the accepting edge
    assign is_short  = (size_kind == SK_SHORT);
    assign is_hex_in = (op == OP_HEXL) || (op == OP_HEXU);
    assign is_num_in = is_hex_in || (op == OP_SDEC) || (op == OP_UDEC);
    assign x_in      = is_short ? {16'h0, value[15:0]} : value;
    assign negx_in   = 32'd0 - x_in;
    assign neg_in    = (op == OP_SDEC) && (is_short ? value[15] : value[31]);
    assign mag_in    = !neg_in ? x_in : (is_short ? {16'h0, negx_in[15:0]} : negx_in);

    pff_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept && is_num_in),
        .mag      (mag_in),
        .is_hex   (is_hex_in),
        .is_short (is_short),
        .res      (conv_res)
    );

    // field plan from the held item and the digit count
    logic [5:0] w_sat;
    logic [5:0] w_eff;
    logic [1:0] plen;
    logic [7:0] pfx0;
    logic [7:0] pfx1;
    logic [3:0] tlen_body;
    logic [3:0] tlen_emit;
    logic       is_num;
    logic       valid_op;
    logic [5:0] pr_lim;
    logic [5:0] pr_sat;
    logic [6:0] target;
    logic [5:0] zeros;
    logic [6:0] body;
    logic [5:0] spaces;
    logic [6:0] total;

    always_comb
    begin
        w_sat     = (w_reg > MAX_FIELD) ? MAX_FIELD : w_reg;
        w_eff     = w_sat;
        plen      = 2'd0;
        pfx0      = CH_SPACE;
        pfx1      = CH_SPACE;
        tlen_body = 4'd1;
        tlen_emit = 4'd1;
        is_num    = 1'b0;
        valid_op  = 1'b1;
        unique case (op_reg)
            OP_LIT:
            begin
                w_eff     = 6'd0;
                tlen_emit = (chr_reg != CH_NUL) ? 4'd1 : 4'd0;
                if (chr_reg == CH_LF)
                begin
                    plen = 2'd1;
                    pfx0 = CH_CR;
                end
            end
            OP_PCT:
            begin
                tlen_emit = 4'd1;
            end
            OP_CHR:
            begin
                tlen_emit = (chr_reg != CH_NUL) ? 4'd1 : 4'd0;
            end
            OP_SDEC, OP_UDEC:
            begin
                is_num    = 1'b1;
                tlen_body = conv_res.tlen;
                tlen_emit = conv_res.tlen;
                if (op_reg == OP_SDEC)
                begin
                    priority if (neg_reg)
                    begin
                        plen = 2'd1;
                        pfx0 = CH_MINUS;
                    end
                    else if (plus_reg)
                    begin
                        plen = 2'd1;
                        pfx0 = CH_PLUS;
                    end
                    else if (space_reg)
                    begin
                        plen = 2'd1;
                        pfx0 = CH_SPACE;
                    end
                    else
                    begin
                        plen = 2'd0;
                    end
                end
            end
            OP_HEXL, OP_HEXU:
            begin
                is_num    = 1'b1;
                tlen_body = conv_res.tlen;
                tlen_emit = conv_res.tlen;
                if (alt_reg)
                begin
                    plen = 2'd2;
                    pfx0 = CH_ZERO;
                    pfx1 = (op_reg == OP_HEXL) ? CH_X_LO : CH_X_UP;
                end
            end
            default:
            begin
                valid_op  = 1'b0;
                tlen_emit = 4'd0;
            end
        endcase

        pr_lim = MAX_FIELD - {4'd0, plen};
        pr_sat = (pr_reg > pr_lim) ? pr_lim : pr_reg;
        target = {1'b0, w_eff} - {5'd0, plen};
        zeros  = 6'd0;
        if (is_num)
        begin
            if (hp_reg)
            begin
                if (pr_sat > {2'd0, tlen_body})
                    zeros = pr_sat - {2'd0, tlen_body};
            end
            else if (zero_reg && !left_reg)
            begin
                if (!target[6] && target[5:0] > {2'd0, tlen_body})
                    zeros = target[5:0] - {2'd0, tlen_body};
            end
        end
        body   = {5'd0, plen} + {1'b0, zeros} + {3'd0, tlen_body};
        spaces = ({1'b0, w_eff} > body) ? (w_eff - body[5:0]) : 6'd0;
        total  = {1'b0, spaces} + {5'd0, plen} + {1'b0, zeros} + {3'd0, tlen_emit};
        if (!valid_op)
            total = 7'd0;

        plan.lead   = left_reg ? 6'd0 : spaces;
        plan.trail  = left_reg ? spaces : 6'd0;
        plan.plen   = plen;
        plan.pfx0   = pfx0;
        plan.pfx1   = pfx1;
        plan.zeros  = zeros;
        plan.tlen   = tlen_emit;
        plan.total  = total[5:0];
        plan.is_num = is_num;
        plan.upper  = (op_reg == OP_HEXU);
        plan.txt    = (op_reg == OP_PCT) ? CH_PCT : chr_reg;
    end

    assign emit_load = (state_reg == ST_PLAN);

    pff_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (emit_load),
        .plan     (plan),
        .digits   (conv_res.digits),
        .busy     (emit_busy),
        .strobe   (strobe),
        .out_char (out_char),
        .last     (last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op;
                        chr_reg   <= value[7:0];
                        neg_reg   <= neg_in;
                        left_reg  <= flag_left;
                        plus_reg  <= flag_plus;
                        space_reg <= flag_space;
                        alt_reg   <= flag_alt;
                        zero_reg  <= flag_zero;
                        w_reg     <= field_width;
                        hp_reg    <= has_precision;
                        pr_reg    <= digit_precision;
                        state_reg <= is_num_in ? ST_CONV : ST_PLAN;
                    end
                end
                ST_CONV:
                begin
                    if (conv_res.done)
                        state_reg <= ST_PLAN;
                end
                ST_PLAN:
                begin
                    state_reg <= (plan.total == 6'd0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!emit_busy)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy did not rise after an accepted item");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");

    a_field_contig: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("gap inside a field");

    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("idle while a field is still going out");

endmodule

`default_nettype wire
